### rtl/pfd_pkg.sv
package pfd_pkg;

  localparam int unsigned SIDE     = 5;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned ROW_W    = SIDE * LETTER_W;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned BUF_DEPTH = 4;

  localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
  localparam logic [LETTER_W-1:0] CODE_J = 5'd9;

  localparam logic [ROW_W-1:0]    ROW0_RST   = 25'd4294688;
  localparam logic [ROW_W-1:0]    ROW1_RST   = 25'd10755269;
  localparam logic [ROW_W-1:0]    ROW2_RST   = 25'd16201099;
  localparam logic [ROW_W-1:0]    ROW3_RST   = 25'd21613104;
  localparam logic [ROW_W-1:0]    ROW4_RST   = 25'd27025109;
  localparam logic [LETTER_W-1:0] FILLER_RST = 5'd23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0   = 3'd0,
    CFG_ROW1   = 3'd1,
    CFG_ROW2   = 3'd2,
    CFG_ROW3   = 3'd3,
    CFG_ROW4   = 3'd4,
    CFG_FILLER = 3'd5
  } cfg_idx_e;

  typedef logic [SIDE-1:0][ROW_W-1:0] square_t;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] cipher_letter;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] cipher_x;
    logic [LETTER_W-1:0] cipher_y;
  } pair_res_t;

  // Load request from the pairing logic into the result buffer
  typedef struct packed {
    logic                load;
    logic [CNT_W-1:0]    count;
    logic [LETTER_W-1:0] cipher_x;
    logic [LETTER_W-1:0] cipher_y;
    logic                last_second;
  } buf_load_t;

  typedef struct packed {
    logic room;
  } buf_status_t;

  // The letter j always stands for i
  function automatic logic [LETTER_W-1:0] map_j(input logic [LETTER_W-1:0] v);
    map_j = (v == CODE_J) ? CODE_I : v;
  endfunction

endpackage

### rtl/pfd_square_cfg.sv
module pfd_square_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pfd_pkg::ROW_W-1:0]       cfg_data_i,
  output pfd_pkg::square_t                square_o,
  output logic [pfd_pkg::LETTER_W-1:0]    filler_o
);
  import pfd_pkg::*;

  square_t             square_q;
  logic [LETTER_W-1:0] filler_q;

  // Write one register; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      square_q[0] <= ROW0_RST;
      square_q[1] <= ROW1_RST;
      square_q[2] <= ROW2_RST;
      square_q[3] <= ROW3_RST;
      square_q[4] <= ROW4_RST;
      filler_q    <= FILLER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW0:   square_q[0] <= cfg_data_i;
        CFG_ROW1:   square_q[1] <= cfg_data_i;
        CFG_ROW2:   square_q[2] <= cfg_data_i;
        CFG_ROW3:   square_q[3] <= cfg_data_i;
        CFG_ROW4:   square_q[4] <= cfg_data_i;
        CFG_FILLER: filler_q    <= cfg_data_i[LETTER_W-1:0];
        default: ;
      endcase
    end
  end

  assign square_o = square_q;
  assign filler_o = map_j(filler_q);

endmodule

### rtl/pfd_pair_cipher.sv
module pfd_pair_cipher (
  input  pfd_pkg::square_t                square_i,
  input  logic [pfd_pkg::LETTER_W-1:0]    first_i,
  input  logic [pfd_pkg::LETTER_W-1:0]    second_i,
  output pfd_pkg::pair_res_t              res_o
);
  import pfd_pkg::*;

  logic [POS_W-1:0] r1, c1, r2, c2;
  logic [POS_W-1:0] r1_dn, c1_rt, r2_dn, c2_rt;

  function automatic logic [LETTER_W-1:0] cell_at(input square_t sq,
                                                  input logic [POS_W-1:0] r,
                                                  input logic [POS_W-1:0] c);
    cell_at = sq[r][LETTER_W*c +: LETTER_W];
  endfunction

  function automatic logic [POS_W-1:0] step_wrap(input logic [POS_W-1:0] p);
    step_wrap = (p == POS_W'(SIDE - 1)) ? '0 : p + POS_W'(1);
  endfunction

  // Locate both letters; the last match in row-major order wins
  always_comb begin
    r1 = '0;
    c1 = '0;
    r2 = '0;
    c2 = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if (square_i[r][LETTER_W*c +: LETTER_W] == first_i) begin
          r1 = POS_W'(r);
          c1 = POS_W'(c);
        end
        if (square_i[r][LETTER_W*c +: LETTER_W] == second_i) begin
          r2 = POS_W'(r);
          c2 = POS_W'(c);
        end
      end
    end
  end

  assign r1_dn = step_wrap(r1);
  assign r2_dn = step_wrap(r2);
  assign c1_rt = step_wrap(c1);
  assign c2_rt = step_wrap(c2);

  // Apply row, column or rectangle rule
  always_comb begin
    if (r1 == r2) begin
      res_o.cipher_x = cell_at(square_i, r1, c1_rt);
      res_o.cipher_y = cell_at(square_i, r2, c2_rt);
    end else if (c1 == c2) begin
      res_o.cipher_x = cell_at(square_i, r1_dn, c1);
      res_o.cipher_y = cell_at(square_i, r2_dn, c2);
    end else begin
      res_o.cipher_x = cell_at(square_i, r1, c2);
      res_o.cipher_y = cell_at(square_i, r2, c1);
    end
  end

endmodule

### rtl/pfd_result_buf.sv
module pfd_result_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pfd_pkg::buf_load_t   load_i,
  output pfd_pkg::buf_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pfd_pkg::out_item_t   out_data_o
);
  import pfd_pkg::*;

  logic [LETTER_W-1:0] lt_q   [BUF_DEPTH];
  logic                last_q [BUF_DEPTH];
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign status_o.room = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && pop);

  // Count of waiting results
  always_comb begin
    cnt_d = cnt_q;
    if (load_i.load) begin
      cnt_d = load_i.count;
    end else if (pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Load a fresh batch, or shift toward the head on each pop
  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      lt_q[0]   <= load_i.cipher_x;
      lt_q[1]   <= load_i.cipher_y;
      lt_q[2]   <= load_i.cipher_x;
      lt_q[3]   <= load_i.cipher_y;
      last_q[0] <= 1'b0;
      last_q[1] <= load_i.last_second;
      last_q[2] <= 1'b0;
      last_q[3] <= 1'b1;
    end else if (pop) begin
      for (int i = 0; i < BUF_DEPTH - 1; i++) begin
        lt_q[i]   <= lt_q[i+1];
        last_q[i] <= last_q[i+1];
      end
    end
  end

  assign out_valid_o              = (cnt_q != '0);
  assign out_data_o.cipher_letter = lt_q[0];
  assign out_data_o.last          = last_q[0];

endmodule

### rtl/playfair_digraph_encrypt.sv
// Channel  Direction  Payload                          Handshake
// in       input      letter, end_of_message           in_valid_i / in_stall_o
// out      output     cipher_letter, last              out_valid_o / out_stall_i
// cfg      input      square rows 0..4, filler letter  cfg_we_i, cfg_idx_i, cfg_data_i
//
// An accepted item waits in the input register until the result buffer has room, then its
// pair, if it completes one, is encrypted and loaded into a four-entry result buffer.
// Results leave through the single output port at one per cycle while the output is not
// stalled, so an item that gives a pair yields two results, a doubled final letter four.
// Reset loads the plain a..z square without j and filler x, and clears the held letter.
// A stalled output holds the buffer; the input stalls once the buffer cannot take the next batch.
module playfair_digraph_encrypt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pfd_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pfd_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pfd_pkg::ROW_W-1:0]     cfg_data_i
);
  import pfd_pkg::*;

  square_t             square;
  logic [LETTER_W-1:0] filler;
  pair_res_t           pair_res;
  buf_load_t           buf_load;
  buf_status_t         buf_status;

  logic                in_v_q;
  logic [LETTER_W-1:0] in_letter_q;
  logic                in_eom_q;
  logic [LETTER_W-1:0] held_q, held_d;
  logic                held_v_q, held_v_d;

  logic                in_take, xfer, same;
  logic [LETTER_W-1:0] first, second;
  logic [CNT_W-1:0]    count;

  pfd_square_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .square_o   (square),
    .filler_o   (filler)
  );

  assign xfer       = in_v_q && buf_status.room;
  assign in_stall_o = in_v_q && !buf_status.room;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_take) begin
      in_v_q <= 1'b1;
    end else if (xfer) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_letter_q <= map_j(in_data_i.letter);
      in_eom_q    <= in_data_i.end_of_message;
    end
  end

  // Form the digraph from the held letter and the new one, padding a lone or repeated letter with the filler
  assign same   = (in_letter_q == held_q);
  assign first  = held_v_q ? held_q : in_letter_q;
  assign second = (held_v_q && !same) ? in_letter_q : filler;

  always_comb begin
    held_d   = held_q;
    held_v_d = held_v_q;
    count    = '0;
    if (!held_v_q) begin
      if (in_eom_q) begin
        count  = CNT_W'(2);
        held_d = '0;
      end else begin
        held_d   = in_letter_q;
        held_v_d = 1'b1;
      end
    end else if (same) begin
      count = in_eom_q ? CNT_W'(4) : CNT_W'(2);
      if (in_eom_q) begin
        held_d   = '0;
        held_v_d = 1'b0;
      end
    end else begin
      count    = CNT_W'(2);
      held_d   = '0;
      held_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      held_v_q <= 1'b0;
    end else if (xfer) begin
      held_q   <= held_d;
      held_v_q <= held_v_d;
    end
  end

  pfd_pair_cipher u_cipher (
    .square_i (square),
    .first_i  (first),
    .second_i (second),
    .res_o    (pair_res)
  );

  // Hand the encrypted pair to the result buffer
  assign buf_load.load        = xfer;
  assign buf_load.count       = count;
  assign buf_load.cipher_x    = pair_res.cipher_x;
  assign buf_load.cipher_y    = pair_res.cipher_y;
  assign buf_load.last_second = in_eom_q && !(held_v_q && same);

  pfd_result_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (buf_load),
    .status_o    (buf_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### test/playfair_digraph_encrypt_tb.sv
`timescale 1ns / 100ps

module playfair_digraph_encrypt_tb;
  import pfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_item_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_item_t out_data_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ROW_W-1:0] cfg_data_i;

  // Shadow copy of the key square, filler and pending letter
  square_t key_sq;
  logic [LETTER_W-1:0] filler_q;
  logic [LETTER_W-1:0] held_q;
  logic held_v;
  out_item_t cipher_q[$];

  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;

  playfair_digraph_encrypt u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Fold j onto i
  function automatic logic [LETTER_W-1:0] fold_j(input logic [LETTER_W-1:0] v);
    return (v == CODE_J) ? CODE_I : v;
  endfunction

  function automatic logic [LETTER_W-1:0] sq_at(input int r, input int c);
    return key_sq[r][LETTER_W*c +: LETTER_W];
  endfunction

  // Last match in row-major order wins; a missing letter sits at row 0, column 0
  function automatic void find_pos(input logic [LETTER_W-1:0] v, output int r, output int c);
    r = 0;
    c = 0;
    for (int i = 0; i < SIDE; i++)
      for (int k = 0; k < SIDE; k++)
        if (sq_at(i, k) == v) begin
          r = i;
          c = k;
        end
  endfunction

  // Encrypt one digraph and queue its two cipher letters
  function automatic void push_pair(input logic [LETTER_W-1:0] a, input logic [LETTER_W-1:0] b,
                                    input logic fin);
    int r1, c1, r2, c2;
    logic [LETTER_W-1:0] x, y;
    out_item_t res;
    find_pos(a, r1, c1);
    find_pos(b, r2, c2);
    if (r1 == r2) begin
      x = sq_at(r1, (c1 + 1) % SIDE);
      y = sq_at(r2, (c2 + 1) % SIDE);
    end else if (c1 == c2) begin
      x = sq_at((r1 + 1) % SIDE, c1);
      y = sq_at((r2 + 1) % SIDE, c2);
    end else begin
      x = sq_at(r1, c2);
      y = sq_at(r2, c1);
    end
    res.cipher_letter = x;
    res.last = 1'b0;
    cipher_q.push_back(res);
    res.cipher_letter = y;
    res.last = fin;
    cipher_q.push_back(res);
  endfunction

  // Pair up one plaintext letter and queue what it yields
  function automatic void predict_letter(input in_item_t it);
    logic [LETTER_W-1:0] l, f;
    l = fold_j(it.letter);
    f = fold_j(filler_q);
    if (!held_v) begin
      if (it.end_of_message) begin
        push_pair(l, f, 1'b1);
      end else begin
        held_q = l;
        held_v = 1'b1;
      end
    end else if (l == held_q) begin
      push_pair(held_q, f, 1'b0);
      if (it.end_of_message) begin
        push_pair(l, f, 1'b1);
        held_v = 1'b0;
        held_q = '0;
      end
    end else begin
      push_pair(held_q, l, it.end_of_message);
      held_v = 1'b0;
      held_q = '0;
    end
  endfunction

  // Check each accepted cipher letter against the oldest expected one
  always @(posedge clk_i) begin : mon
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cipher_q.size() == 0) begin
        $error("unexpected item: cipher_letter %0d last %0b",
               out_data_o.cipher_letter, out_data_o.last);
        fail_cnt++;
      end else begin
        want = cipher_q.pop_front();
        if (out_data_o.cipher_letter !== want.cipher_letter) begin
          $error("cipher_letter: expected %0d, actual %0d",
                 want.cipher_letter, out_data_o.cipher_letter);
          fail_cnt++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_data_o.last);
          fail_cnt++;
        end
      end
    end
  end

  // Output stall: long hold-off on request, else random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (burst_left > 0) begin
      out_stall_i <= 1'b1;
      burst_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      burst_left = $urandom_range(1, 6) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Offer one item, with an optional gap first, and hold it until accepted
  task automatic send_letter(input in_item_t it);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_letter(it);
  endtask

  task automatic send_code(input int unsigned l, input bit eom);
    in_item_t it;
    it.letter = l[LETTER_W-1:0];
    it.end_of_message = eom;
    send_letter(it);
  endtask

  // Drop valid and wait until every expected item has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; the caller lowers the write enable afterwards
  task automatic write_reg(input cfg_idx_e idx, input logic [ROW_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CFG_FILLER) filler_q = data[LETTER_W-1:0];
    else key_sq[int'(idx)] = data;
  endtask

  task automatic load_square(input square_t sq, input logic [LETTER_W-1:0] fill);
    logic [ROW_W-LETTER_W-1:0] junk;
    junk = (ROW_W - LETTER_W)'($urandom());
    write_reg(CFG_ROW0, sq[0]);
    write_reg(CFG_ROW1, sq[1]);
    write_reg(CFG_ROW2, sq[2]);
    write_reg(CFG_ROW3, sq[3]);
    write_reg(CFG_ROW4, sq[4]);
    write_reg(CFG_FILLER, {junk, fill});
    cfg_we_i <= 1'b0;
  endtask

  // Shuffle the 25 letters without j into a square
  function automatic square_t shuffled_square();
    logic [LETTER_W-1:0] pool[25];
    logic [LETTER_W-1:0] tmp;
    square_t sq;
    int n, k;
    n = 0;
    for (int v = 0; v < 26; v++)
      if (v != CODE_J) begin
        pool[n] = LETTER_W'(v);
        n++;
      end
    for (int i = 24; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = pool[i];
      pool[i] = pool[k];
      pool[k] = tmp;
    end
    for (int i = 0; i < 25; i++) sq[i / SIDE][LETTER_W*(i % SIDE) +: LETTER_W] = pool[i];
    return sq;
  endfunction

  // Random messages: many repeated letters, some ends, closed at the end
  task automatic random_run(input int n, input bit wide_codes);
    in_item_t it;
    logic [LETTER_W-1:0] prev;
    int unsigned pick;
    prev = '0;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) it.letter = prev;
      else if (wide_codes && pick == 3) it.letter = LETTER_W'($urandom_range(26, 31));
      else it.letter = LETTER_W'($urandom_range(0, 25));
      it.end_of_message = ($urandom_range(0, 7) == 0);
      send_letter(it);
      prev = it.letter;
    end
    if (held_v) send_code($urandom_range(0, 25), 1'b1);
    settle();
  endtask

  // Plain square: row, column and rectangle rules and the pairing cases
  task automatic test_directed_letters();
    // same row, same column, rectangle
    send_code(0, 0);  send_code(1, 0);
    send_code(0, 0);  send_code(5, 0);
    send_code(0, 0);  send_code(25, 0);
    // doubled letter restarts with the repeat held
    send_code(4, 0);  send_code(4, 0);  send_code(3, 0);
    // j folds to i, so ji is a doubled letter
    send_code(9, 0);  send_code(8, 0);  send_code(7, 1);
    // lone final letter gets padded
    send_code(2, 1);
    // doubled letter at the end gives four items
    send_code(25, 0); send_code(25, 1);
    // doubled filler
    send_code(23, 0); send_code(23, 1);
    // codes outside the alphabet
    send_code(31, 0); send_code(26, 1);
    send_code(28, 1);
    settle();
  endtask

  // Filler extremes, j as filler, and filler bits above the code
  task automatic test_filler_extremes();
    logic [ROW_W-1:0] vals[4];
    vals[0] = '0;
    vals[1] = '1;
    vals[2] = {20'($urandom()), 5'd25};
    vals[3] = {20'($urandom()), CODE_J};
    foreach (vals[i]) begin
      write_reg(CFG_FILLER, vals[i]);
      cfg_we_i <= 1'b0;
      send_code(17, 0); send_code(17, 0);
      send_code(11, 1);
      send_code(6, 1);
      send_code(14, 0); send_code(14, 1);
      settle();
    end
  endtask

  task automatic test_random_squares();
    for (int k = 0; k < 3; k++) begin
      load_square(shuffled_square(), LETTER_W'($urandom_range(0, 25)));
      random_run(20, 1'b0);
    end
  endtask

  // Squares with missing and repeated letters
  task automatic test_odd_squares();
    square_t sq;
    sq = '0;
    load_square(sq, 5'd0);
    random_run(12, 1'b1);
    sq = '1;
    load_square(sq, 5'd31);
    random_run(12, 1'b1);
    for (int r = 0; r < SIDE; r++) sq[r] = ROW_W'($urandom());
    load_square(sq, LETTER_W'($urandom_range(0, 31)));
    random_run(12, 1'b1);
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_long_hold();
    load_square(shuffled_square(), LETTER_W'($urandom_range(0, 25)));
    hold_req = 1'b1;
    random_run(20, 1'b0);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    random_run(20, 1'b1);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    key_sq[0] = ROW0_RST;
    key_sq[1] = ROW1_RST;
    key_sq[2] = ROW2_RST;
    key_sq[3] = ROW3_RST;
    key_sq[4] = ROW4_RST;
    filler_q = FILLER_RST;
    held_q = '0;
    held_v = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_letters();
    test_filler_extremes();
    test_random_squares();
    test_odd_squares();
    test_long_hold();
    test_steady_stream();

    if (cipher_q.size() != 0) begin
      $error("%0d expected items never arrived", cipher_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
